/* rtl/core/dwrd_pkg.sv */
// ----------------------------------------------------------------------------
// dwrd_pkg
// Types and constants shared by the date window record decoder.
// ----------------------------------------------------------------------------
package dwrd_pkg;

  // register stages of one calendar conversion unit
  localparam int unsigned CalStages = 6;

  localparam logic [15:0] EpochMjd  = 16'd51604;  // MJD of 2000-03-01
  localparam logic [15:0] Days100y  = 16'd36524;
  localparam logic [10:0] Days4y    = 11'd1461;
  localparam logic [10:0] Days1y    = 11'd365;
  localparam logic [11:0] Recip4y   = 12'd2870;   // floor(2^22 / 1461)
  localparam int unsigned Recip4yShift = 22;
  localparam logic [10:0] MonMul    = 11'd1071;
  localparam logic [18:0] MonAdd    = 19'd450;
  localparam logic [9:0]  DomMul    = 10'd979;
  localparam logic [13:0] DomAdd    = 14'd16;
  localparam logic [11:0] BaseYear  = 12'd2000;
  localparam logic [7:0]  Years100  = 8'd100;
  localparam logic [4:0]  MonShift  = 5'd3;
  localparam logic [4:0]  MonsYear  = 5'd12;

  typedef struct packed {
    logic [7:0]  group_id;
    logic [7:0]  hold_hours;
    logic [15:0] net_id;
    logic [15:0] ts_id;
  } dwrd_pass_t;

  // day counts are already rebased to 2000-03-01, modulo 2^16
  typedef struct packed {
    logic [15:0] day_start;
    logic [15:0] day_end;
    dwrd_pass_t  pass;
  } dwrd_entry_t;

endpackage

/* rtl/core/dwrd_if.sv */
// ----------------------------------------------------------------------------
// dwrd_if
// Valid/ready channels for control records and decoded date windows.
// ----------------------------------------------------------------------------
interface dwrd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  group_id;
  logic [15:0] reference_day;
  logic [7:0]  days_back;
  logic [7:0]  span_days;
  logic [7:0]  hold_hours;
  logic [15:0] net_id;
  logic [15:0] ts_id;

  modport source (
    output valid, group_id, reference_day, days_back, span_days, hold_hours,
           net_id, ts_id,
    input  ready
  );
  modport sink (
    input  valid, group_id, reference_day, days_back, span_days, hold_hours,
           net_id, ts_id,
    output ready
  );
endinterface

interface dwrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  group_out;
  logic [11:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_date;
  logic [11:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_date;
  logic [7:0]  hold_out;
  logic [15:0] network_out;
  logic [15:0] transport_out;

  modport source (
    output valid, group_out, start_year, start_month, start_date, end_year,
           end_month, end_date, hold_out, network_out, transport_out,
    input  ready
  );
  modport sink (
    input  valid, group_out, start_year, start_month, start_date, end_year,
           end_month, end_date, hold_out, network_out, transport_out,
    output ready
  );
endinterface

/* rtl/core/date_window_record_decoder_core.sv */
// ----------------------------------------------------------------------------
// date_window_record_decoder_core
// Decodes a control record into start and end calendar dates.
// ----------------------------------------------------------------------------
// Path: the front register loads on acceptance, then the queue write and six
//   conversion stages lead to result valid. The pipeline is fully staged.
// Throughput: one request per cycle unless the output stalls the pipeline.
// Reset: rst_ni clears the front, queue and pipeline valid state at once.
// ----------------------------------------------------------------------------
module date_window_record_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwrd_in_if.sink     in_i,
  dwrd_out_if.source  out_o
);
  import dwrd_pkg::*;

  logic        front_valid, front_ready;
  dwrd_entry_t front_entry;
  logic        queue_valid, queue_ready;
  dwrd_entry_t queue_entry;

  dwrd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .entry_valid_o (front_valid),
    .entry_ready_i (front_ready),
    .entry_o       (front_entry)
  );

  dwrd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_entry),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_entry)
  );

  dwrd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_ready_o (queue_ready),
    .entry_i       (queue_entry),
    .out_o         (out_o)
  );

endmodule

/* rtl/core/dwrd_front.sv */
// ----------------------------------------------------------------------------
// dwrd_front
// Accepts control records and forms rebased start and end day counts.
// ----------------------------------------------------------------------------
module dwrd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dwrd_in_if.sink             in_i,
  output logic                entry_valid_o,
  input  logic                entry_ready_i,
  output dwrd_pkg::dwrd_entry_t entry_o
);
  import dwrd_pkg::*;

  logic        valid_q;
  dwrd_entry_t entry_q;
  dwrd_entry_t entry_d;
  logic        load;

  assign in_i.ready = !valid_q || entry_ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    // all day arithmetic wraps at 16 bits
    entry_d.day_start = in_i.reference_day - {8'd0, in_i.days_back} - EpochMjd;
    entry_d.day_end   = entry_d.day_start + {8'd0, in_i.span_days} - 16'd1;
    entry_d.pass.group_id   = in_i.group_id;
    entry_d.pass.hold_hours = in_i.hold_hours;
    entry_d.pass.net_id     = in_i.net_id;
    entry_d.pass.ts_id      = in_i.ts_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign entry_valid_o = valid_q;
  assign entry_o       = entry_q;

endmodule

/* rtl/core/dwrd_fifo.sv */
// ----------------------------------------------------------------------------
// dwrd_fifo
// Short request queue between the front and the conversion pipeline.
// ----------------------------------------------------------------------------
module dwrd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  dwrd_pkg::dwrd_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output dwrd_pkg::dwrd_entry_t pop_data_o
);
  import dwrd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dwrd_entry_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/dwrd_cal.sv */
// ----------------------------------------------------------------------------
// dwrd_cal
// Six-stage day count to calendar date conversion, epoch 2000-03-01.
// ----------------------------------------------------------------------------
module dwrd_cal (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] day_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  date_o
);
  import dwrd_pkg::*;

  // stage 1: century split (the 16-bit count never reaches 400 years)
  logic        s1_q100_q, s1_q100_d;
  logic [15:0] s1_r100_q, s1_r100_d;
  // stage 2: reciprocal estimate of the 4-year quotient
  logic        s2_q100_q;
  logic [15:0] s2_r100_q;
  logic [4:0]  s2_qe_q, s2_qe_d;
  logic [27:0] s2_prod;
  // stage 3: correct the estimate
  logic        s3_q100_q;
  logic [4:0]  s3_q4_q, s3_q4_d;
  logic [10:0] s3_r4_q, s3_r4_d;
  logic [15:0] s3_mul, s3_rem;
  logic        s3_fix;
  // stage 4: year within the 4-year period, capped at 3
  logic        s4_q100_q;
  logic [4:0]  s4_q4_q;
  logic [1:0]  s4_q1_q, s4_q1_d;
  logic [8:0]  s4_r1_q, s4_r1_d;
  logic [10:0] s4_sub;
  // stage 5: month index from March, year offset
  logic [3:0]  s5_mraw_q, s5_mraw_d;
  logic [8:0]  s5_r1_q;
  logic [7:0]  s5_yoff_q, s5_yoff_d;
  logic [18:0] s5_sum;
  // stage 6: day of month, month wrap
  logic [11:0] s6_year_q, s6_year_d;
  logic [3:0]  s6_month_q, s6_month_d;
  logic [4:0]  s6_date_q, s6_date_d;
  logic [13:0] s6_sum;
  logic [8:0]  s6_dom;
  logic [4:0]  s6_mon;
  logic        s6_wrap;

  always_comb begin
    s1_q100_d = (day_i >= Days100y);
    s1_r100_d = s1_q100_d ? day_i - Days100y : day_i;

    // estimate is exact or one low for counts below 36524
    s2_prod = 28'(s1_r100_q) * 28'(Recip4y);
    s2_qe_d = s2_prod[Recip4yShift +: 5];

    s3_mul  = 16'(s2_qe_q) * 16'(Days4y);
    s3_rem  = s2_r100_q - s3_mul;
    s3_fix  = (s3_rem >= 16'(Days4y));
    s3_q4_d = s2_qe_q + 5'(s3_fix);
    s3_r4_d = s3_fix ? 11'(s3_rem - 16'(Days4y)) : 11'(s3_rem);

    if (s3_r4_q >= 11'(3 * Days1y)) begin
      s4_q1_d = 2'd3;
    end else if (s3_r4_q >= 11'(2 * Days1y)) begin
      s4_q1_d = 2'd2;
    end else if (s3_r4_q >= Days1y) begin
      s4_q1_d = 2'd1;
    end else begin
      s4_q1_d = 2'd0;
    end
    s4_sub  = 11'(s4_q1_d) * Days1y;
    s4_r1_d = 9'(s3_r4_q - s4_sub);

    s5_sum    = 19'(s4_r1_q) * 19'(MonMul) + MonAdd;
    s5_mraw_d = s5_sum[18:15];
    s5_yoff_d = (s4_q100_q ? Years100 : 8'd0) + {1'b0, s4_q4_q, 2'b00}
              + {6'd0, s4_q1_q};

    s6_sum     = 14'(s5_mraw_q) * 14'(DomMul) + DomAdd;
    s6_dom     = s5_r1_q - s6_sum[13:5] + 9'd1;
    s6_date_d  = s6_dom[4:0];
    s6_mon     = {1'b0, s5_mraw_q} + MonShift;
    s6_wrap    = (s6_mon > MonsYear);
    s6_month_d = s6_wrap ? 4'(s6_mon - MonsYear) : 4'(s6_mon);
    s6_year_d  = BaseYear + {4'd0, s5_yoff_q} + 12'(s6_wrap);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q100_q  <= s1_q100_d;
      s1_r100_q  <= s1_r100_d;
      s2_q100_q  <= s1_q100_q;
      s2_r100_q  <= s1_r100_q;
      s2_qe_q    <= s2_qe_d;
      s3_q100_q  <= s2_q100_q;
      s3_q4_q    <= s3_q4_d;
      s3_r4_q    <= s3_r4_d;
      s4_q100_q  <= s3_q100_q;
      s4_q4_q    <= s3_q4_q;
      s4_q1_q    <= s4_q1_d;
      s4_r1_q    <= s4_r1_d;
      s5_mraw_q  <= s5_mraw_d;
      s5_r1_q    <= s4_r1_q;
      s5_yoff_q  <= s5_yoff_d;
      s6_year_q  <= s6_year_d;
      s6_month_q <= s6_month_d;
      s6_date_q  <= s6_date_d;
    end
  end

  assign year_o  = s6_year_q;
  assign month_o = s6_month_q;
  assign date_o  = s6_date_q;

endmodule

/* rtl/core/dwrd_back.sv */
// ----------------------------------------------------------------------------
// dwrd_back
// Conversion pipeline for start and end days, with the result register.
// ----------------------------------------------------------------------------
module dwrd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  output logic                  entry_ready_o,
  input  dwrd_pkg::dwrd_entry_t entry_i,
  dwrd_out_if.source            out_o
);
  import dwrd_pkg::*;

  logic [CalStages-1:0] valid_q;
  dwrd_pass_t           pass_q [CalStages];
  logic                 advance;

  // whole pipeline moves together; it only holds when the last stage is stuck
  assign advance       = !valid_q[CalStages-1] || out_o.ready;
  assign entry_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[CalStages-2:0], entry_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pass_q[0] <= entry_i.pass;
      for (int i = 1; i < CalStages; i++) begin
        pass_q[i] <= pass_q[i-1];
      end
    end
  end

  dwrd_cal u_cal_start (
    .clk_i   (clk_i),
    .en_i    (advance),
    .day_i   (entry_i.day_start),
    .year_o  (out_o.start_year),
    .month_o (out_o.start_month),
    .date_o  (out_o.start_date)
  );

  dwrd_cal u_cal_end (
    .clk_i   (clk_i),
    .en_i    (advance),
    .day_i   (entry_i.day_end),
    .year_o  (out_o.end_year),
    .month_o (out_o.end_month),
    .date_o  (out_o.end_date)
  );

  assign out_o.valid         = valid_q[CalStages-1];
  assign out_o.group_out     = pass_q[CalStages-1].group_id;
  assign out_o.hold_out      = pass_q[CalStages-1].hold_hours;
  assign out_o.network_out   = pass_q[CalStages-1].net_id;
  assign out_o.transport_out = pass_q[CalStages-1].ts_id;

endmodule

/* verif/tb_date_window_record_decoder_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_window_record_decoder_core
// Self-checking bench for the date window decoder. Control records go in over
// a valid/ready channel, and a scoreboard predicts the calendar start and end
// dates of each request. Decoded windows are checked field by field in order,
// under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_date_window_record_decoder_core;

  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned TimeoutNs = 4_000_000;
  localparam int unsigned PhaseReqs = 183;
  localparam int unsigned TailCycles = 24;

  typedef struct {
    logic [7:0]  group_id;
    logic [15:0] reference_day;
    logic [7:0]  days_back;
    logic [7:0]  span_days;
    logic [7:0]  hold_hours;
    logic [15:0] net_id;
    logic [15:0] ts_id;
  } record_t;

  typedef struct {
    logic [7:0]  group_out;
    logic [11:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_date;
    logic [11:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_date;
    logic [7:0]  hold_out;
    logic [15:0] network_out;
    logic [15:0] transport_out;
  } window_t;

  class window_scoreboard;
    localparam logic [15:0] EpochDay = 16'd51604;  // MJD of 2000-03-01
    localparam int unsigned Days400y = 146097;
    localparam int unsigned Days100y = 36524;
    localparam int unsigned Days4y   = 1461;
    localparam int unsigned Days1y   = 365;
    localparam int unsigned FirstYear = 2000;

    window_t     expected_windows[$];
    int unsigned requests;
    int unsigned windows;
    int unsigned errors;

    // Gregorian date from a day number, year counted from March 1st
    function void day_to_date(input logic [15:0] day, output logic [11:0] yr,
                              output logic [3:0] mo, output logic [4:0] dm);
      logic [15:0] rebased;
      int unsigned d, q400, r400, q100, r100, q4, r4, q1, r1, mon, dom, year;
      rebased = day - EpochDay;
      d    = {16'd0, rebased};
      q400 = d / Days400y;
      r400 = d % Days400y;
      q100 = r400 / Days100y;
      r100 = r400 - q100 * Days100y;
      q4   = r100 / Days4y;
      r4   = r100 - q4 * Days4y;
      q1   = r4 / Days1y;
      if (q1 > 3) begin
        q1 = 3;  // Feb 29 of the leap year
      end
      r1   = r4 - q1 * Days1y;
      mon  = (1071 * r1 + 450) >> 15;
      dom  = r1 - ((979 * mon + 16) >> 5);
      year = q400 * 400 + q100 * 100 + q4 * 4 + q1 + FirstYear;
      mon  = mon + 3;
      if (mon > 12) begin
        mon  = mon - 12;
        year = year + 1;
      end
      dom = dom + 1;
      yr = year[11:0];
      mo = mon[3:0];
      dm = dom[4:0];
    endfunction

    function void note_request(record_t r);
      window_t     w;
      logic [15:0] first_day, last_day;
      first_day = r.reference_day - {8'h00, r.days_back};
      last_day  = first_day + {8'h00, r.span_days} - 16'd1;
      w.group_out     = r.group_id;
      w.hold_out      = r.hold_hours;
      w.network_out   = r.net_id;
      w.transport_out = r.ts_id;
      day_to_date(first_day, w.start_year, w.start_month, w.start_date);
      day_to_date(last_day, w.end_year, w.end_month, w.end_date);
      expected_windows.push_back(w);
      requests++;
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        $display("%0t ns: window %0d %s mismatch: expected %0d, got %0d",
                 $time, windows, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_window(window_t got);
      window_t exp_w;
      if (expected_windows.size() == 0) begin
        $display("%0t ns: unexpected window, group %0d start %0d-%0d-%0d",
                 $time, got.group_out, got.start_year, got.start_month, got.start_date);
        errors++;
        return;
      end
      exp_w = expected_windows.pop_front();
      compare_field("group_out", exp_w.group_out, got.group_out);
      compare_field("start_year", exp_w.start_year, got.start_year);
      compare_field("start_month", exp_w.start_month, got.start_month);
      compare_field("start_date", exp_w.start_date, got.start_date);
      compare_field("end_year", exp_w.end_year, got.end_year);
      compare_field("end_month", exp_w.end_month, got.end_month);
      compare_field("end_date", exp_w.end_date, got.end_date);
      compare_field("hold_out", exp_w.hold_out, got.hold_out);
      compare_field("network_out", exp_w.network_out, got.network_out);
      compare_field("transport_out", exp_w.transport_out, got.transport_out);
      windows++;
    endfunction

    function int unsigned pending();
      return expected_windows.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  dwrd_in_if  in_ch ();
  dwrd_out_if out_ch ();

  date_window_record_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  window_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned directed_reqs;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    window_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      w.group_out     = out_ch.group_out;
      w.start_year    = out_ch.start_year;
      w.start_month   = out_ch.start_month;
      w.start_date    = out_ch.start_date;
      w.end_year      = out_ch.end_year;
      w.end_month     = out_ch.end_month;
      w.end_date      = out_ch.end_date;
      w.hold_out      = out_ch.hold_out;
      w.network_out   = out_ch.network_out;
      w.transport_out = out_ch.transport_out;
      sb.check_window(w);
    end
  end

  function automatic record_t make_record(logic [15:0] ref_day, logic [7:0] back,
                                          logic [7:0] span);
    record_t r;
    r.group_id      = 8'($urandom_range(255));
    r.reference_day = ref_day;
    r.days_back     = back;
    r.span_days     = span;
    r.hold_hours    = 8'($urandom_range(255));
    r.net_id        = 16'($urandom_range(65535));
    r.ts_id         = 16'($urandom_range(65535));
    return r;
  endfunction

  function automatic record_t random_record();
    logic [15:0] ref_day;
    logic [7:0]  span;
    // a share of low reference days so the start often wraps below zero
    ref_day = ($urandom_range(9) == 0) ? 16'($urandom_range(255))
                                       : 16'($urandom_range(65535));
    span    = ($urandom_range(4) == 0) ? 8'($urandom_range(3))
                                       : 8'($urandom_range(255));
    return make_record(ref_day, 8'($urandom_range(255)), span);
  endfunction

  task automatic send_record(record_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.group_id      <= r.group_id;
    in_ch.reference_day <= r.reference_day;
    in_ch.days_back     <= r.days_back;
    in_ch.span_days     <= r.span_days;
    in_ch.hold_hours    <= r.hold_hours;
    in_ch.net_id        <= r.net_id;
    in_ch.ts_id         <= r.ts_id;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    sb.note_request(r);
  endtask

  // stop sending and let every outstanding window come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    record_t r;
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.group_id      = '0;
    in_ch.reference_day = '0;
    in_ch.days_back     = '0;
    in_ch.span_days     = '0;
    in_ch.hold_hours    = '0;
    in_ch.net_id        = '0;
    in_ch.ts_id         = '0;
    out_ch.ready        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all-zero record: start wraps below zero, zero span
    r = '{8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000};
    send_record(r);
    r = '{8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff};
    send_record(r);
    send_record(make_record(16'd51604, 8'd0, 8'd1));    // 2000-03-01
    send_record(make_record(16'd51604, 8'd0, 8'd0));    // end falls before epoch
    send_record(make_record(16'd51909, 8'd0, 8'd2));    // year boundary
    send_record(make_record(16'd51968, 8'd0, 8'd2));    // Feb 28 into Mar 1
    send_record(make_record(16'd53064, 8'd0, 8'd1));    // leap day, capped year split
    send_record(make_record(16'd53063, 8'd0, 8'd3));
    send_record(make_record(16'd53066, 8'd1, 8'd2));
    send_record(make_record(16'd22591, 8'd0, 8'd2));    // century year, not leap
    send_record(make_record(16'd51603, 8'd0, 8'd1));    // top of the day count
    send_record(make_record(16'd0, 8'd255, 8'd255));
    send_record(make_record(16'd100, 8'd200, 8'd0));
    send_record(make_record(16'd255, 8'd255, 8'd1));
    send_record(make_record(16'd65535, 8'd0, 8'd255));  // end wraps past 16 bits
    send_record(make_record(16'd51750, 8'd10, 8'd40));
    directed_reqs = sb.requests;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (PhaseReqs) send_record(random_record());
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d control records (%0d directed, the rest random) and checked %0d windows",
             sb.requests, directed_reqs, sb.windows);
    $display("across no-idle, sender-idle, receiver-stall and mixed handshake phases.");
    if (sb.errors == 0) begin
      $display("** date_window_record_decoder_core: PASSED **");
    end else begin
      $display("** date_window_record_decoder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d windows outstanding", sb.pending());
    $display("** date_window_record_decoder_core: FAILED **");
    $finish;
  end

endmodule
